FILE: sv/conv2x2_ceil_average_assert.svh
// Assertion macros for the conv2x2_ceil_average block.
// Included by the top level; needs nothing else.
`ifndef CONV2X2_CEIL_AVERAGE_ASSERT_SVH
`define CONV2X2_CEIL_AVERAGE_ASSERT_SVH

// same-cycle implication, held off during reset
`define CCA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("cca assertion failed");

// next-cycle implication, held off during reset
`define CCA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("cca assertion failed");

`endif

FILE: sv/cca_pkg.sv
// Shared constants and types for the 2x2 ceiling-average convolution.
// No dependencies; imported by every module of the block.
package cca_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LB_AW      = $clog2(MAX_WIDTH);
  localparam int CW         = 10;           // row / column tag width
  localparam int PIX_W      = 16;
  localparam int VAL_W      = 32;
  localparam int SIZE_W     = 11;           // frame size register width
  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 16;
  localparam int QDEPTH     = 4;
  localparam int QAW        = $clog2(QDEPTH);

  // register indexes
  localparam logic [CFG_IW-1:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_COEF_TL      = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_COEF_TR      = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_COEF_BL      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_COEF_BR      = 3'd5;

  // pending result kinds of one job, emitted low bit first
  localparam int PEND_CONV  = 0;
  localparam int PEND_ABOVE = 1;
  localparam int PEND_PIXEL = 2;

  typedef struct packed {
    logic signed [PIX_W-1:0] tl;
    logic signed [PIX_W-1:0] tr;
    logic signed [PIX_W-1:0] bl;
    logic signed [PIX_W-1:0] br;
  } coef_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] ul;
    logic signed [PIX_W-1:0] above;
    logic signed [PIX_W-1:0] left;
    logic signed [PIX_W-1:0] px;
    logic [CW-1:0]           row;
    logic [CW-1:0]           col;
    logic [2:0]              pend;
  } job_t;

  typedef struct packed {
    logic [CW-1:0]           row;
    logic [CW-1:0]           col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } res_t;

endpackage

FILE: sv/cca_front.sv
// Front end: position counters, line buffer and window assembly.
// Depends on cca_pkg; feeds classified jobs into cca_jobq.
module cca_front
  import cca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    restart,
  input  logic [CW-1:0]           last_col,
  input  logic [CW-1:0]           last_row,
  input  logic                    in_push,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                    in_full,
  output logic                    jq_push,
  output job_t                    jq_job,
  input  logic                    jq_full
);

  logic signed [PIX_W-1:0] lbuf [MAX_WIDTH];
  logic signed [PIX_W-1:0] above_r;
  logic [CW-1:0]           col_r, col_nxt, row_r, row_nxt;
  logic                    f1_valid_r, f1_valid_nxt;
  logic signed [PIX_W-1:0] f1_px_r;
  logic [CW-1:0]           f1_row_r, f1_col_r;
  logic signed [PIX_W-1:0] left_r, ul_r;
  logic                    accept, f1_adv;
  logic [2:0]              pend;

  assign in_full = f1_valid_r && jq_full;
  assign accept  = in_push && !in_full;
  assign f1_adv  = f1_valid_r && !jq_full;

  // raster position of the next word
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_r == last_col) begin
        col_nxt = '0;
        row_nxt = (row_r == last_row) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line buffer: read old row value, write new one at the same column
  always_ff @(posedge clk) begin
    if (accept) begin
      lbuf[col_r[LB_AW-1:0]] <= in_pixel;
      above_r                <= lbuf[col_r[LB_AW-1:0]];
    end
  end

  // stage 1 holds the accepted word until the job queue takes it
  always_comb begin
    f1_valid_nxt = f1_valid_r;
    if (accept)      f1_valid_nxt = 1'b1;
    else if (f1_adv) f1_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f1_valid_r <= 1'b0;
    else        f1_valid_r <= f1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_px_r  <= in_pixel;
      f1_row_r <= row_r;
      f1_col_r <= col_r;
    end
  end

  // window history moves on with every word, job or not
  always_ff @(posedge clk) begin
    if (f1_adv) begin
      left_r <= f1_px_r;
      ul_r   <= above_r;
    end
  end

  // classify
  always_comb begin
    pend             = '0;
    pend[PEND_CONV]  = (f1_row_r != '0) && (f1_col_r != '0);
    pend[PEND_ABOVE] = (f1_row_r != '0) && (f1_col_r == last_col);
    pend[PEND_PIXEL] = (f1_row_r == last_row);
  end

  assign jq_push      = f1_adv && (pend != '0);
  assign jq_job.ul    = ul_r;
  assign jq_job.above = above_r;
  assign jq_job.left  = left_r;
  assign jq_job.px    = f1_px_r;
  assign jq_job.row   = f1_row_r;
  assign jq_job.col   = f1_col_r;
  assign jq_job.pend  = pend;

endmodule

FILE: sv/cca_jobq.sv
// Short job queue between front end and back end.
// Depends on cca_pkg.
module cca_jobq
  import cca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == QAW'(0) + (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_job;
  end

endmodule

FILE: sv/cca_back.sv
// Back end: weighted window sum, ceiling quarter and result expansion.
// Depends on cca_pkg; pops cca_jobq and pushes cca_resq.
module cca_back
  import cca_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  coef_t coef,
  input  logic  jq_empty,
  input  job_t  jq_job,
  output logic  jq_pop,
  input  logic  rq_full,
  output logic  rq_push,
  output res_t  rq_res
);

  localparam int SUM_W = VAL_W + 2;

  // stage b1: products
  logic                    b1_valid_r;
  logic signed [VAL_W-1:0] p_tl_r, p_tr_r, p_bl_r, p_br_r;
  job_t                    b1_job_r;
  // stage b2: value ready, results emitted one a cycle unless the result queue is full
  logic                    b2_valid_r, b2_valid_nxt;
  logic signed [VAL_W-1:0] conv_r;
  job_t                    b2_job_r;
  logic [2:0]              pend_r, pend_nxt;

  logic                    b1_free, b1_move, b2_free, emit, last;
  logic [2:0]              sel;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] quarter;

  assign emit    = b2_valid_r && !rq_full;
  assign b2_free = !b2_valid_r || (emit && last);
  assign b1_move = b1_valid_r && b2_free;
  assign b1_free = !b1_valid_r || b1_move;
  assign jq_pop  = !jq_empty && b1_free;

  // b1: one multiplier per tap
  always_ff @(posedge clk) begin
    if (!rst_n) b1_valid_r <= 1'b0;
    else if (b1_free) b1_valid_r <= !jq_empty;
  end

  always_ff @(posedge clk) begin
    if (jq_pop) begin
      p_tl_r   <= coef.tl * jq_job.ul;
      p_tr_r   <= coef.tr * jq_job.above;
      p_bl_r   <= coef.bl * jq_job.left;
      p_br_r   <= coef.br * jq_job.px;
      b1_job_r <= jq_job;
    end
  end

  // ceil(s/4) == floor((s+3)/4) for every integer s
  always_comb begin
    sum = SUM_W'(p_tl_r) + SUM_W'(p_tr_r) + SUM_W'(p_bl_r) + SUM_W'(p_br_r)
        + SUM_W'(3);
    quarter = sum >>> 2;
  end

  // pick the oldest pending result kind
  always_comb begin
    sel = '0;
    if (pend_r[PEND_CONV])       sel[PEND_CONV]  = 1'b1;
    else if (pend_r[PEND_ABOVE]) sel[PEND_ABOVE] = 1'b1;
    else                         sel[PEND_PIXEL] = 1'b1;
    last = ((pend_r & ~sel) == '0);
  end

  always_comb begin
    b2_valid_nxt = b2_valid_r;
    pend_nxt     = pend_r;
    if (b2_free) begin
      b2_valid_nxt = b1_valid_r;
      pend_nxt     = b1_job_r.pend;
    end else if (emit) begin
      pend_nxt = pend_r & ~sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
      pend_r     <= '0;
    end else begin
      b2_valid_r <= b2_valid_nxt;
      pend_r     <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_move) begin
      conv_r   <= quarter[VAL_W-1:0];
      b2_job_r <= b1_job_r;
    end
  end

  // result word
  assign rq_push = emit;
  always_comb begin
    rq_res.last = last;
    if (sel[PEND_CONV]) begin
      rq_res.row   = b2_job_r.row - 1'b1;
      rq_res.col   = b2_job_r.col - 1'b1;
      rq_res.value = conv_r;
    end else if (sel[PEND_ABOVE]) begin
      rq_res.row   = b2_job_r.row - 1'b1;
      rq_res.col   = b2_job_r.col;
      rq_res.value = VAL_W'(b2_job_r.above);
    end else begin
      rq_res.row   = b2_job_r.row;
      rq_res.col   = b2_job_r.col;
      rq_res.value = VAL_W'(b2_job_r.px);
    end
  end

endmodule

FILE: sv/cca_resq.sv
// Result queue that drives the output ports.
// Depends on cca_pkg.
module cca_resq
  import cca_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  input  logic pop,
  output res_t head,
  output logic empty
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop)      cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_res;
  end

endmodule

FILE: sv/conv2x2_ceil_average.sv
// Top level of the streaming 2x2 ceiling-average convolution.
// Depends on cca_pkg, cca_front, cca_jobq, cca_back, cca_resq and the assert header.
//
//  channel | ports                                        | word accepted when
//  --------+----------------------------------------------+-------------------
//  input   | in_push, in_full, in_pixel                   | in_push & !in_full
//  result  | out_empty, out_pop, out_row/col/value/last   | out_pop & !out_empty
//  config  | cfg_we, cfg_index, cfg_data                  | cfg_we
//
// One pixel per clock is sustained while neither side stalls; a pixel can yield up
// to 3 results (3 only at the last column and last row) and holds the back end until all are emitted.
// The first result of a pixel passes stage 1, the job queue, b1, b2 and the result queue.
// Reset is synchronous; the line buffer needs no clearing pass.
// Either side may stall; the job and result queues absorb edge bursts.
module conv2x2_ceil_average
  import cca_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  input  logic signed [PIX_W-1:0] in_pixel,
  output logic                    in_full,
  output logic                    out_empty,
  input  logic                    out_pop,
  output logic [CW-1:0]           out_row,
  output logic [CW-1:0]           out_col,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CFG_DW-1:0]       cfg_data
);

  logic [CW-1:0]     last_col_r, last_row_r;
  coef_t             coef_r;
  logic              restart;
  logic [SIZE_W-1:0] size_raw;
  logic [SIZE_W-1:0] size_max;
  logic [CW-1:0]     size_last;

  logic jq_push, jq_full, jq_pop, jq_empty;
  job_t jq_in, jq_head;
  logic rq_push, rq_full;
  res_t rq_in, rq_head;

  // frame size: zero acts as one, oversize saturates to that dimension's maximum
  assign size_raw = cfg_data[SIZE_W-1:0];
  assign size_max = (cfg_index == CFG_FRAME_HEIGHT) ? SIZE_W'(MAX_HEIGHT)
                                                    : SIZE_W'(MAX_WIDTH);
  always_comb begin
    if (size_raw == '0)           size_last = '0;
    else if (size_raw > size_max) size_last = CW'(size_max - 1'b1);
    else                          size_last = CW'(size_raw - 1'b1);
  end

  assign restart = cfg_we &&
                   (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_col_r <= CW'(MAX_WIDTH - 1);
      last_row_r <= CW'(MAX_HEIGHT - 1);
      coef_r.tl  <= 16'sd1;
      coef_r.tr  <= 16'sd1;
      coef_r.bl  <= 16'sd1;
      coef_r.br  <= 16'sd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  last_col_r <= size_last;
        CFG_FRAME_HEIGHT: last_row_r <= size_last;
        CFG_COEF_TL:      coef_r.tl  <= cfg_data;
        CFG_COEF_TR:      coef_r.tr  <= cfg_data;
        CFG_COEF_BL:      coef_r.bl  <= cfg_data;
        CFG_COEF_BR:      coef_r.br  <= cfg_data;
        default: ;
      endcase
    end
  end

  cca_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (restart),
    .last_col (last_col_r),
    .last_row (last_row_r),
    .in_push  (in_push),
    .in_pixel (in_pixel),
    .in_full  (in_full),
    .jq_push  (jq_push),
    .jq_job   (jq_in),
    .jq_full  (jq_full)
  );

  cca_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (jq_push),
    .push_job (jq_in),
    .full     (jq_full),
    .pop      (jq_pop),
    .head     (jq_head),
    .empty    (jq_empty)
  );

  cca_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef_r),
    .jq_empty (jq_empty),
    .jq_job   (jq_head),
    .jq_pop   (jq_pop),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_res   (rq_in)
  );

  cca_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rq_push),
    .push_res (rq_in),
    .full     (rq_full),
    .pop      (out_pop),
    .head     (rq_head),
    .empty    (out_empty)
  );

  assign out_row   = rq_head.row;
  assign out_col   = rq_head.col;
  assign out_value = rq_head.value;
  assign out_last  = rq_head.last;

  `include "conv2x2_ceil_average_assert.svh"

  // a job always carries at least one result
  `CCA_ASSERT_NOW(a_job_nonempty, clk, rst_n, jq_push, jq_in.pend != 3'b000)
  // the back end never overruns the result queue
  `CCA_ASSERT_NOW(a_no_overrun, clk, rst_n, rq_push, !rq_full)
  // a size write with nothing queued leaves the block able to take a pixel
  `CCA_ASSERT_NEXT(a_restart_ready, clk, rst_n, restart && jq_empty && !in_full, !in_full)

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for conv2x2_ceil_average: an in-bench window predictor
// checks every result word. Depends on cca_pkg and the conv2x2_ceil_average RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cca_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 12;   // covers the pipeline latency plus queue slack
  localparam logic [CFG_IW-1:0] SPARE_INDEX_LO = 3'd6;
  localparam logic [CFG_IW-1:0] SPARE_INDEX_HI = 3'd7;
  localparam logic [CFG_DW-1:0] COEF_MIN = 16'h8000;
  localparam logic [CFG_DW-1:0] COEF_MAX = 16'h7fff;
  localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;
  localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;

  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    in_push = 1'b0;
  logic signed [PIX_W-1:0] in_pixel = '0;
  logic                    in_full;
  logic                    out_empty;
  logic                    out_pop = 1'b0;
  logic [CW-1:0]           out_row;
  logic [CW-1:0]           out_col;
  logic signed [VAL_W-1:0] out_value;
  logic                    out_last;
  logic                    cfg_we = 1'b0;
  logic [CFG_IW-1:0]       cfg_index = '0;
  logic [CFG_DW-1:0]       cfg_data = '0;

  conv2x2_ceil_average u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_pixel  (in_pixel),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predictor state: registers, line store, window taps, raster position
  logic [SIZE_W-1:0]       frame_w_reg;
  logic [SIZE_W-1:0]       frame_h_reg;
  coef_t                   coefs;
  logic signed [PIX_W-1:0] row_store [MAX_WIDTH];
  logic signed [PIX_W-1:0] left_px;
  logic signed [PIX_W-1:0] upper_left_px;
  int                      col_pos;
  int                      row_pos;
  res_t                    pending_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int pixels_sent;
  int results_checked;
  int reg_writes;
  int mismatches;
  int cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d words still expected", cycles,
             pending_results.size());
    $display("conv2x2_ceil_average regression: fail");
    $finish;
  end

  function automatic int frame_extent(input logic [SIZE_W-1:0] raw, input int max_size);
    if (raw == 0) return 1;
    if (raw > max_size) return max_size;
    return int'(raw);
  endfunction

  // ceiling of s/4; truncating division already rounds negatives up
  function automatic longint ceil_quarter(input longint s);
    if (s >= 0) return (s + 3) / 4;
    return s / 4;
  endfunction

  function automatic logic signed [PIX_W-1:0] pick_sample();
    logic [PIX_W-1:0] v;
    v = PIX_W'($urandom());
    case ($urandom_range(0, 7))
      0: v = PIX_MIN;
      1: v = PIX_MAX;
      2: v = '0;
      3: v = v[2:0] - 16'd4;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DW-1:0] pick_coef();
    logic [CFG_DW-1:0] v;
    v = CFG_DW'($urandom());
    case ($urandom_range(0, 7))
      0: v = COEF_MIN;
      1: v = COEF_MAX;
      2: v = '0;
      3: v = v[2:0] - 16'd3;
      default: ;
    endcase
    return v;
  endfunction

  // upper data bits random; the block keeps only the low 11
  function automatic logic [CFG_DW-1:0] pick_size(input int hi);
    logic [CFG_DW-1:0] v;
    v = CFG_DW'($urandom());
    case ($urandom_range(0, 9))
      0: v[SIZE_W-1:0] = '0;
      1: v[SIZE_W-1:0] = SIZE_W'($urandom_range(hi + 1, 4 * hi));
      default: v[SIZE_W-1:0] = SIZE_W'($urandom_range(1, hi));
    endcase
    return v;
  endfunction

  task automatic model_reset();
    frame_w_reg = SIZE_W'(MAX_WIDTH);
    frame_h_reg = SIZE_W'(MAX_HEIGHT);
    coefs = '{tl: 16'sd1, tr: 16'sd1, bl: 16'sd1, br: 16'sd1};
    left_px = '0;
    upper_left_px = '0;
    col_pos = 0;
    row_pos = 0;
  endtask

  // expected words for one accepted pixel, then advance the raster position
  task automatic compute_window_results(input logic signed [PIX_W-1:0] px);
    int w;
    int h;
    int r;
    int c;
    int n;
    logic signed [PIX_W-1:0] above;
    logic signed [VAL_W-1:0] v;
    longint acc;
    res_t found [3];
    w = frame_extent(frame_w_reg, MAX_WIDTH);
    h = frame_extent(frame_h_reg, MAX_HEIGHT);
    r = row_pos;
    c = col_pos;
    n = 0;
    above = row_store[c];
    if (r >= 1 && c >= 1) begin
      acc = longint'($signed(coefs.tl)) * longint'(upper_left_px)
          + longint'($signed(coefs.tr)) * longint'(above)
          + longint'($signed(coefs.bl)) * longint'(left_px)
          + longint'($signed(coefs.br)) * longint'(px);
      found[n].row = CW'(r - 1);
      found[n].col = CW'(c - 1);
      found[n].value = VAL_W'(ceil_quarter(acc));
      found[n].last = 1'b0;
      n++;
    end
    // right edge of the row above passes through
    if (r >= 1 && c == w - 1) begin
      v = above;
      found[n].row = CW'(r - 1);
      found[n].col = CW'(c);
      found[n].value = v;
      found[n].last = 1'b0;
      n++;
    end
    // bottom row passes through
    if (r == h - 1) begin
      v = px;
      found[n].row = CW'(r);
      found[n].col = CW'(c);
      found[n].value = v;
      found[n].last = 1'b0;
      n++;
    end
    if (n > 0) found[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_results.push_back(found[k]);
    upper_left_px = above;
    row_store[c] = px;
    left_px = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // result side: random pop, compare each accepted word with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $error("unexpected word: row %0d col %0d value %0d last %0b",
               out_row, out_col, out_value, out_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_row !== want.row) begin
          $error("out_row mismatch: expected %0d, actual %0d", want.row, out_row);
          mismatches++;
        end
        if (out_col !== want.col) begin
          $error("out_col mismatch: expected %0d, actual %0d", want.col, out_col);
          mismatches++;
        end
        if (out_value !== want.value) begin
          $error("out_value mismatch at (%0d,%0d): expected %0d, actual %0d",
                 want.row, want.col, want.value, out_value);
          mismatches++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch at (%0d,%0d): expected %0b, actual %0b",
                 want.row, want.col, want.last, out_last);
          mismatches++;
        end
      end
    end
    out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // push one pixel; push stays high on return so back-to-back words need no toggle
  task automatic send_pixel(input logic signed [PIX_W-1:0] px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push  <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_full !== 1'b0) @(posedge clk);
    compute_window_results(px);
    pixels_sent++;
  endtask

  // drop push, wait for every expected word, then let in-flight pixels retire
  task automatic settle_block();
    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_FRAME_WIDTH: begin
        frame_w_reg = data[SIZE_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      CFG_FRAME_HEIGHT: begin
        frame_h_reg = data[SIZE_W-1:0];
        col_pos = 0;
        row_pos = 0;
      end
      CFG_COEF_TL: coefs.tl = data;
      CFG_COEF_TR: coefs.tr = data;
      CFG_COEF_BL: coefs.bl = data;
      CFG_COEF_BR: coefs.br = data;
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [CFG_DW-1:0] w, input logic [CFG_DW-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  task automatic set_coefs(input logic [CFG_DW-1:0] tl, input logic [CFG_DW-1:0] tr,
                           input logic [CFG_DW-1:0] bl, input logic [CFG_DW-1:0] br);
    write_reg(CFG_COEF_TL, tl);
    write_reg(CFG_COEF_TR, tr);
    write_reg(CFG_COEF_BL, bl);
    write_reg(CFG_COEF_BR, br);
  endtask

  // reset values: the 1024-wide frame keeps the first row silent,
  // then a small frame shows the unit weights
  task automatic test_reset_values();
    repeat (20) send_pixel(pick_sample());
    settle_block();
    set_frame(16'd3, 16'd3);
    repeat (9) send_pixel(pick_sample());
    settle_block();
  endtask

  // largest positive and negative window sums
  task automatic test_extreme_products();
    set_frame(16'd2, 16'd2);
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    repeat (4) send_pixel(PIX_MIN);
    repeat (4) send_pixel(PIX_MAX);
    settle_block();
  endtask

  // sums of 3, -1 and -6 check the ceiling on both sides of zero
  task automatic test_ceiling_rounding();
    set_frame(16'd4, 16'd2);
    set_coefs(16'd1, 16'd1, 16'd1, 16'd1);
    send_pixel(16'sd1);
    send_pixel(16'sd0);
    send_pixel(-16'sd1);
    send_pixel(-16'sd5);
    send_pixel(16'sd2);
    repeat (3) send_pixel(16'sd0);
    settle_block();
  endtask

  // zero sizes act as one; high data bits are ignored
  task automatic test_degenerate_sizes();
    set_frame(16'hf800, 16'h0000);
    send_pixel(PIX_MAX);
    send_pixel(pick_sample());
    settle_block();
  endtask

  // oversize width, then oversize height, both clamp to the maximum;
  // their low ten bits alone would give a tiny frame
  task automatic test_saturated_sizes();
    set_frame(16'h0402, 16'd2);
    repeat (8) send_pixel(pick_sample());
    settle_block();
    set_frame(16'd1, 16'h0403);
    repeat (8) send_pixel(pick_sample());
    settle_block();
  endtask

  // spare indexes leave the frame alone; a size write restarts it
  task automatic test_frame_restart();
    set_frame(16'd3, 16'd2);
    set_coefs(16'd3, -16'd2, 16'd5, -16'd7);
    repeat (4) send_pixel(pick_sample());
    settle_block();
    write_reg(SPARE_INDEX_LO, CFG_DW'($urandom()));
    write_reg(SPARE_INDEX_HI, CFG_DW'($urandom()));
    send_pixel(pick_sample());
    settle_block();
    write_reg(CFG_FRAME_HEIGHT, 16'd2);
    repeat (6) send_pixel(pick_sample());
    settle_block();
  endtask

  // random setups, mostly small frames; some keep the frame running across weight changes
  task automatic run_random_frames(input int quota);
    int first;
    int n;
    int w;
    int h;
    first = pixels_sent;
    while (pixels_sent - first < quota) begin
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_FRAME_WIDTH, pick_size(9));
        write_reg(CFG_FRAME_HEIGHT, pick_size(5));
      end
      set_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
      w = frame_extent(frame_w_reg, MAX_WIDTH);
      h = frame_extent(frame_h_reg, MAX_HEIGHT);
      n = $urandom_range(1, 2 * w * h + 3);
      if (n > 60) n = 60;
      repeat (n) send_pixel(pick_sample());
      settle_block();
    end
  endtask

  initial begin
    model_reset();
    pixels_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    mismatches = 0;
    send_idle_pct = 38;
    recv_idle_pct = 66;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_extreme_products();
    test_ceiling_rounding();
    test_degenerate_sizes();
    test_frame_restart();
    test_saturated_sizes();
    run_random_frames(90);

    send_idle_pct = 66;
    recv_idle_pct = 38;
    run_random_frames(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_frames(90);

    $display("%0d pixels pushed, %0d result words checked, %0d register writes",
             pixels_sent, results_checked, reg_writes);
    $display("covered reset sizes, clamped and zero sizes, extreme weights, rounding,");
    $display("frame restarts and random setups under three stall mixes");
    if (mismatches == 0) begin
      $display("conv2x2_ceil_average regression: pass");
    end else begin
      $display("conv2x2_ceil_average regression: fail");
    end
    $finish;
  end

endmodule
